// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the waveform generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pdwg_pkg.sv -----
// ----------------------------------------------------------------------------
// pdwg_pkg
// Constants, types and the sine table builder of the waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pdwg_pkg;

    localparam int PHASE_BITS       = 24;
    localparam int FRAC_BITS        = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_W           = 16;
    localparam int REG_BITS         = 24;
    localparam int STEP_BITS        = 24;
    localparam int SHAPE_BITS       = 4;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int WAVE_BITS        = 32;
    localparam int MUL_W            = REG_BITS + 1;
    localparam int PROD_W           = 2 * MUL_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [REG_BITS-1:0]   ONE_Q          = REG_BITS'(1) << FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN   = PHASE_BITS'(1) << (PHASE_BITS - 2);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SHAPE_SELECT   = 3'd0,
        REG_RATE_RATIO     = 3'd1,
        REG_REPEAT_COUNT   = 3'd2,
        REG_PHASE_SHIFT    = 3'd3,
        REG_LEVEL_SHIFT    = 3'd4,
        REG_LEVEL_SCALE    = 3'd5,
        REG_CONSTANT_LEVEL = 3'd6
    } cfg_index_t;

    // Shape codes.
    localparam logic [SHAPE_BITS-1:0] SHAPE_CONSTANT  = 4'd0;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SAW       = 4'd1;
    localparam logic [SHAPE_BITS-1:0] SHAPE_TRIANGLE  = 4'd2;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SINE      = 4'd3;
    localparam logic [SHAPE_BITS-1:0] SHAPE_COSINE    = 4'd4;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SLOW_HILL = 4'd5;
    localparam logic [SHAPE_BITS-1:0] SHAPE_FAST_HILL = 4'd6;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SLOW_PIT  = 4'd7;
    localparam logic [SHAPE_BITS-1:0] SHAPE_FAST_PIT  = 4'd8;

    // Request to the shared multiplier.
    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] op_a;
        logic signed [MUL_W-1:0] op_b;
    } mul_req_t;

    typedef logic [SINE_W-1:0] sine_table_t [SINE_TABLE_DEPTH];

    // One odd-power step of the Taylor series, Q30 arithmetic, before the divide.
    function automatic logic [63:0] cube_step(input logic [63:0] term,
                                              input logic [63:0] theta);
        return (((term * theta) >> 30) * theta) >> 30;
    endfunction

    // Quarter-wave table, evaluated at elaboration; entries sample the bin centres.
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] theta;
        logic [63:0] term;
        logic [63:0] e;
        longint      sum;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            theta = (64'(2 * k + 1) * HALF_PI_Q30) / (2 * SINE_TABLE_DEPTH);
            sum   = longint'(theta);
            term  = cube_step(theta, theta) / 64'd6;
            sum   = sum - longint'(term);
            term  = cube_step(term, theta) / 64'd20;
            sum   = sum + longint'(term);
            term  = cube_step(term, theta) / 64'd42;
            sum   = sum - longint'(term);
            term  = cube_step(term, theta) / 64'd72;
            sum   = sum + longint'(term);
            term  = cube_step(term, theta) / 64'd110;
            sum   = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            e = (64'(sum) * 64'd65536 + (64'd1 << 29)) >> 30;
            tbl[k] = (e > 64'd65535) ? {SINE_W{1'b1}} : e[SINE_W-1:0];
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pdwg_mul.sv -----
// ----------------------------------------------------------------------------
// pdwg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwg_mul (
    input  wire                                   aclk,
    input  pdwg_pkg::mul_req_t                    mul_req,
    output logic signed [pdwg_pkg::PROD_W-1:0]    product
);

    logic signed [pdwg_pkg::PROD_W-1:0] product_reg;

    // The product holds until the next request, so a stalled step still sees it.
    always_ff @(posedge aclk) begin
        if (mul_req.en) begin
            product_reg <= mul_req.op_a * mul_req.op_b;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pdwg_sine.sv -----
// ----------------------------------------------------------------------------
// pdwg_sine
// Table sine of a phase angle: quarter-wave ROM with quadrant folding.
// ----------------------------------------------------------------------------
`default_nettype none

module pdwg_sine (
    input  wire                                    aclk,
    input  logic                                   rd_en,
    input  logic [pdwg_pkg::PHASE_BITS-1:0]        angle,
    output logic signed [pdwg_pkg::SINE_W:0]       sine_value
);

    localparam int IDX_W = pdwg_pkg::SINE_ADDR_BITS + 2;
    localparam pdwg_pkg::sine_table_t SINE_ROM = pdwg_pkg::build_sine_table();

    logic [IDX_W-1:0]                    index;
    logic [pdwg_pkg::SINE_ADDR_BITS-1:0] rom_addr;
    logic [pdwg_pkg::SINE_W-1:0]         rom_data_reg;
    logic                                negate_reg;

    assign index = angle[pdwg_pkg::PHASE_BITS-1 -: IDX_W];

    // Odd quadrants read the quarter wave backwards; the upper half is negated.
    assign rom_addr = index[IDX_W-2] ? ~index[pdwg_pkg::SINE_ADDR_BITS-1:0]
                                     : index[pdwg_pkg::SINE_ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rom_data_reg <= SINE_ROM[rom_addr];
            negate_reg   <= index[IDX_W-1];
        end
    end

    assign sine_value = negate_reg ? -$signed({1'b0, rom_data_reg})
                                   :  $signed({1'b0, rom_data_reg});

endmodule

`default_nettype wire

// ----- rtl/core/phase_driven_waveform_generator_core.sv -----
// ----------------------------------------------------------------------------
// phase_driven_waveform_generator_core
// Phase accumulator driven low-frequency generator with nine wave shapes.
// ----------------------------------------------------------------------------
// Channel   Dir   Carries (lowest bits first)
// s_*       in    tdata: time_step, speed, override_time; tuser: override_valid
// m_*       out   tdata: wave_value, phase_out
// cfg_wr_*  in    register index and write data, no read-back
//
// An item passes the steps from TR to OUT, or from RPT on when it loads an
// override time, before the next one can be taken; they use the single 25 by
// 25 bit multiplier, five passes or two with an override, and the registered sine ROM.
// s_tready is high only while the sequencer waits for an item. A finished
// result waits in the output register, and a new item is taken meanwhile; the
// sequencer stalls in its last step only if that register is still occupied.
// Reset is synchronous: it clears the phase and restores the registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module phase_driven_waveform_generator_core (
    input  wire          aclk,
    input  wire          aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,       // time_step[23:0], speed[47:24], override_time[71:48]
    input  logic [0:0]   s_tuser,       // override_valid[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,       // wave_value[31:0], phase_out[55:32]
    input  logic         cfg_wr_en,
    input  logic [pdwg_pkg::CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [pdwg_pkg::REG_BITS-1:0]       cfg_wr_data
);

    localparam int PB  = pdwg_pkg::PHASE_BITS;
    localparam int FB  = pdwg_pkg::FRAC_BITS;
    localparam int RB  = pdwg_pkg::REG_BITS;
    localparam int MW  = pdwg_pkg::MUL_W;
    localparam int PW  = pdwg_pkg::PROD_W;
    localparam int WB  = pdwg_pkg::WAVE_BITS;
    localparam int SW  = pdwg_pkg::SINE_W;
    localparam int GW  = SW + 2;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_TR    = 11'b00000000010,
        ST_LO    = 11'b00000000100,
        ST_HI    = 11'b00000001000,
        ST_PHASE = 11'b00000010000,
        ST_RPT   = 11'b00000100000,
        ST_XFORM = 11'b00001000000,
        ST_ROM   = 11'b00010000000,
        ST_GFORM = 11'b00100000000,
        ST_SCALE = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [pdwg_pkg::SHAPE_BITS-1:0] shape_reg;
    logic [RB-1:0] rate_ratio_reg;
    logic [RB-1:0] repeat_count_reg;
    logic [RB-1:0] phase_shift_reg;
    logic [RB-1:0] level_shift_reg;
    logic [RB-1:0] level_scale_reg;
    logic [RB-1:0] constant_level_reg;

    // Datapath registers.
    logic [pdwg_pkg::STEP_BITS-1:0] time_step_reg;
    logic [RB-1:0]                  speed_reg;
    logic [RB-1:0]                  step_hi_reg;
    logic [PW-RB-1:0]               lo_top_reg;
    logic [PB-1:0]                  phase_reg, phase_next;
    logic [PB-1:0]                  x_reg, x_next;
    logic signed [MW-1:0]           sum_reg, sum_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [WB-1:0]                  wave_reg, wave_next;
    logic [PB-1:0]                  phase_out_reg;

    logic                           s_accept;
    logic                           out_load;
    pdwg_pkg::mul_req_t             mul_req;
    logic signed [PW-1:0]           mul_product;
    logic [PB-1:0]                  sine_angle;
    logic signed [SW:0]             sine_value;
    logic [PB+1:0]                  three_x;
    logic [PB+1:0]                  tri_val;
    logic signed [GW-1:0]           hill_sum;
    logic signed [GW-1:0]           hill;
    logic signed [GW-1:0]           g_val;
    logic [31:0]                    inc_upper;
    logic [PB-1:0]                  phase_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_load = (state_reg == ST_OUT) & (~m_tvalid_reg | m_tready);

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg          <= pdwg_pkg::SHAPE_SAW;
            rate_ratio_reg     <= pdwg_pkg::ONE_Q;
            repeat_count_reg   <= pdwg_pkg::ONE_Q;
            phase_shift_reg    <= '0;
            level_shift_reg    <= '0;
            level_scale_reg    <= pdwg_pkg::ONE_Q;
            constant_level_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                pdwg_pkg::REG_SHAPE_SELECT: begin
                    shape_reg <= cfg_wr_data[pdwg_pkg::SHAPE_BITS-1:0];
                end
                pdwg_pkg::REG_RATE_RATIO:     rate_ratio_reg     <= cfg_wr_data;
                pdwg_pkg::REG_REPEAT_COUNT:   repeat_count_reg   <= cfg_wr_data;
                pdwg_pkg::REG_PHASE_SHIFT:    phase_shift_reg    <= cfg_wr_data;
                pdwg_pkg::REG_LEVEL_SHIFT:    level_shift_reg    <= cfg_wr_data;
                pdwg_pkg::REG_LEVEL_SCALE:    level_scale_reg    <= cfg_wr_data;
                pdwg_pkg::REG_CONSTANT_LEVEL: constant_level_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and sine ROM
    // ------------------------------------------------------------------
    always_comb begin
        mul_req = '0;
        case (state_reg)
            ST_TR: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({1'b0, time_step_reg});
                mul_req.op_b = $signed({1'b0, rate_ratio_reg});
            end
            ST_LO: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({1'b0, mul_product[RB-1:0]});
                mul_req.op_b = $signed({speed_reg[RB-1], speed_reg});
            end
            ST_HI: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({1'b0, step_hi_reg});
                mul_req.op_b = $signed({speed_reg[RB-1], speed_reg});
            end
            ST_RPT: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({1'b0, phase_reg});
                mul_req.op_b = $signed({repeat_count_reg[RB-1], repeat_count_reg});
            end
            ST_SCALE: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = sum_reg;
                mul_req.op_b = $signed({level_scale_reg[RB-1], level_scale_reg});
            end
            default: begin
            end
        endcase
    end

    pdwg_mul u_mul (
        .aclk    (aclk),
        .mul_req (mul_req),
        .product (mul_product)
    );

    assign three_x = {2'b00, x_reg} + {1'b0, x_reg, 1'b0};

    always_comb begin
        case (shape_reg)
            pdwg_pkg::SHAPE_COSINE:    sine_angle = x_reg + pdwg_pkg::QUARTER_TURN;
            pdwg_pkg::SHAPE_SLOW_HILL,
            pdwg_pkg::SHAPE_SLOW_PIT:  sine_angle = three_x[PB+1:2] - pdwg_pkg::QUARTER_TURN;
            pdwg_pkg::SHAPE_FAST_HILL,
            pdwg_pkg::SHAPE_FAST_PIT:  sine_angle = {1'b0, x_reg[PB-1:1]};
            default:                   sine_angle = x_reg;
        endcase
    end

    pdwg_sine u_sine (
        .aclk       (aclk),
        .rd_en      (state_reg == ST_ROM),
        .angle      (sine_angle),
        .sine_value (sine_value)
    );

    // ------------------------------------------------------------------
    // Phase increment: bits [55:32] of time_step * rate * speed. The high
    // partial product has no bits below bit 24, so only the top part of the
    // low partial product is kept.
    // ------------------------------------------------------------------
    assign inc_upper = {{(32 - (PW - RB)){lo_top_reg[PW-RB-1]}}, lo_top_reg}
                       + mul_product[31:0];
    assign phase_inc = inc_upper[31:8];

    always_comb begin
        phase_next = phase_reg;
        if (s_accept && s_tuser[0]) begin
            phase_next = {s_tdata[48 +: FB], {(PB - FB){1'b0}}};
        end else if (state_reg == ST_PHASE) begin
            phase_next = phase_reg + phase_inc;
        end
    end

    assign x_next = mul_product[PB+FB-1:FB] + {phase_shift_reg[FB-1:0], {(PB - FB){1'b0}}};

    // ------------------------------------------------------------------
    // Shape evaluation
    // ------------------------------------------------------------------
    assign tri_val  = x_reg[PB-1] ? ((PB+2)'(1) << (PB + 1)) - {1'b0, x_reg, 1'b0}
                                  : {1'b0, x_reg, 1'b0};
    assign hill_sum = $signed({sine_value[SW], sine_value})
                      + $signed({1'b0, pdwg_pkg::ONE_Q[SW:0]});
    assign hill     = {hill_sum[GW-1], hill_sum[GW-1:1]};

    always_comb begin
        case (shape_reg)
            pdwg_pkg::SHAPE_SAW:       g_val = $signed({2'b00, x_reg[PB-1 -: SW]});
            pdwg_pkg::SHAPE_TRIANGLE:  g_val = $signed(tri_val[PB+1 -: GW]);
            pdwg_pkg::SHAPE_SINE,
            pdwg_pkg::SHAPE_COSINE,
            pdwg_pkg::SHAPE_FAST_HILL: g_val = $signed({sine_value[SW], sine_value});
            pdwg_pkg::SHAPE_SLOW_HILL: g_val = hill;
            pdwg_pkg::SHAPE_SLOW_PIT:  g_val = -hill;
            pdwg_pkg::SHAPE_FAST_PIT:  g_val = -$signed({sine_value[SW], sine_value});
            default:                   g_val = '0;
        endcase
    end

    assign sum_next = $signed({{(MW - GW){g_val[GW-1]}}, g_val})
                      + $signed({level_shift_reg[RB-1], level_shift_reg});

    // Saturate scaled value, dropping FB fraction bits; SHAPE_CONSTANT uses its level.
    always_comb begin
        case (shape_reg)
            pdwg_pkg::SHAPE_CONSTANT: begin
                wave_next = {{(WB - RB){constant_level_reg[RB-1]}}, constant_level_reg};
            end
            pdwg_pkg::SHAPE_SAW,
            pdwg_pkg::SHAPE_TRIANGLE,
            pdwg_pkg::SHAPE_SINE,
            pdwg_pkg::SHAPE_COSINE,
            pdwg_pkg::SHAPE_SLOW_HILL,
            pdwg_pkg::SHAPE_FAST_HILL,
            pdwg_pkg::SHAPE_SLOW_PIT,
            pdwg_pkg::SHAPE_FAST_PIT: begin
                if ((mul_product[PW-1:WB+FB-1] == '0) || (mul_product[PW-1:WB+FB-1] == '1)) begin
                    wave_next = mul_product[WB+FB-1:FB];
                end else if (mul_product[PW-1]) begin
                    wave_next = {1'b1, {(WB - 1){1'b0}}};
                end else begin
                    wave_next = {1'b0, {(WB - 1){1'b1}}};
                end
            end
            default: wave_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_tuser[0] ? ST_RPT : ST_TR;
                end
            end
            ST_TR:    state_next = ST_LO;
            ST_LO:    state_next = ST_HI;
            ST_HI:    state_next = ST_PHASE;
            ST_PHASE: state_next = ST_RPT;
            ST_RPT:   state_next = ST_XFORM;
            ST_XFORM: state_next = ST_ROM;
            ST_ROM:   state_next = ST_GFORM;
            ST_GFORM: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            time_step_reg <= s_tdata[0 +: pdwg_pkg::STEP_BITS];
            speed_reg     <= s_tdata[24 +: RB];
        end
        if (state_reg == ST_LO) begin
            step_hi_reg <= mul_product[2*RB-1:RB];
        end
        if (state_reg == ST_HI) begin
            lo_top_reg <= mul_product[PW-1:RB];
        end
        if (state_reg == ST_XFORM) begin
            x_reg <= x_next;
        end
        if (state_reg == ST_GFORM) begin
            sum_reg <= sum_next;
        end
        if (out_load) begin
            wave_reg      <= wave_next;
            phase_out_reg <= phase_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {phase_out_reg, wave_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_result_after_last_step, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_OUT), "result raised outside the output step")
    `ASSERT_NEXT(a_phase_held, aclk, aresetn, !s_accept && (state_reg != ST_PHASE), $stable(phase_reg), "phase changed outside its update step")
    `ASSERT_NEXT(a_out_stall_holds, aclk, aresetn, (state_reg == ST_OUT) && m_tvalid_reg && !m_tready, state_reg == ST_OUT, "sequencer left the output step while the result register was full")

endmodule

`default_nettype wire
